// ----- sv/rth_pkg.sv -----
// Shared widths, constants and pipeline types for the RGB to HSV converter.
package rth_pkg;

	// Field widths
	localparam int CH_W   = 8;
	localparam int HUE_W  = 12;
	localparam int SAT_W  = 10;
	localparam int VAL_W  = 7;

	// Divider geometry: quotient bits and the numerator that feeds them
	localparam int QUOT_W = 12;
	localparam int NUM_W  = CH_W + QUOT_W;

	// Width of max times the value scale (255 * 100 fits in 15 bits)
	localparam int VX_W   = CH_W + VAL_W;

	// Fixed-point scale factors
	localparam int SEXTANT_TENTHS = 600;
	localparam int FULL_TENTHS    = 3600;
	localparam int SAT_TENTHS     = 1000;
	localparam int VALUE_SCALE    = 100;

	// Channel that holds the maximum
	typedef enum logic [1:0] {
		SEXT_RED   = 2'd0,
		SEXT_GREEN = 2'd1,
		SEXT_BLUE  = 2'd2
	} rth_sext_t;

	// One division lane: partial remainder, numerator bits still to shift in,
	// quotient bits so far and the divisor
	typedef struct packed {
		logic [CH_W-1:0]   pr;
		logic [QUOT_W-1:0] low;
		logic [QUOT_W-1:0] q;
		logic [CH_W-1:0]   den;
	} rth_lane_t;

	// Everything an item carries through the divider stages
	typedef struct packed {
		rth_lane_t        hue;
		rth_lane_t        sat;
		logic             chroma;
		logic [VAL_W-1:0] val;
	} rth_dstage_t;

endpackage

// ----- sv/rgb_to_hsv_unit.sv -----
// Stages from pixel accept to hsv_valid: 2 front stages, 12 divider stages, 1 output register.
// Throughput: one pixel per clock while hsv_stall stays low; the 12-stage restoring divider sets the depth.
// A stalled output backs up only as far as the first empty stage, so bubbles are squeezed out.
// Reset: arst_n clears every stage valid bit at once; payload registers are not reset.
// No warm-up or clearing pass: a pixel is accepted in the first cycle after reset.
module rgb_to_hsv_unit import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  logic [CH_W-1:0]  red_in,
	input  logic [CH_W-1:0]  green_in,
	input  logic [CH_W-1:0]  blue_in,
	output logic             hsv_valid,
	input  logic             hsv_stall,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] saturation,
	output logic [VAL_W-1:0] value_level
);

	logic        front_ready;
	logic        front_valid;
	rth_dstage_t front_data;
	logic        div_ready;
	logic        div_valid;
	rth_dstage_t div_data;
	logic        back_ready;

	assign pixel_stall = !front_ready;

	// Max/min, sextant and numerators
	rth_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.in_ready  (front_ready),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (front_valid),
		.out_ready (div_ready),
		.out_data  (front_data)
	);

	// Hue and saturation division
	rth_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (div_ready),
		.in_data   (front_data),
		.out_valid (div_valid),
		.out_ready (back_ready),
		.out_data  (div_data)
	);

	// Rounding and output register
	rth_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_ready    (back_ready),
		.in_data     (div_data),
		.out_valid   (hsv_valid),
		.out_stall   (hsv_stall),
		.hue         (hue),
		.saturation  (saturation),
		.value_level (value_level)
	);

endmodule

// ----- sv/rth_front.sv -----
// Front stages: max/min and sextant selection, then the hue and saturation numerators.
module rth_front import rth_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CH_W-1:0]   red_in,
	input  logic [CH_W-1:0]   green_in,
	input  logic [CH_W-1:0]   blue_in,
	output logic              out_valid,
	input  logic              out_ready,
	output rth_dstage_t       out_data
);

	// Stage 1 registers
	logic                   v_s1;
	logic [CH_W-1:0]        mx_s1;
	logic [CH_W-1:0]        spread_s1;
	rth_sext_t              sext_s1;
	logic signed [CH_W:0]   diff_s1;

	// Stage 2 registers
	logic                   v_s2;
	rth_dstage_t            data_s2;

	logic adv_s1;
	logic adv_s2;

	// Stage 1 combinational results
	logic [CH_W-1:0]        mx_c;
	logic [CH_W-1:0]        mn_c;
	rth_sext_t              sext_c;
	logic signed [CH_W:0]   diff_c;

	// Stage 2 combinational results
	logic signed [NUM_W:0]  d600_c;
	logic [NUM_W-1:0]       base_c;
	logic signed [NUM_W:0]  total_c;
	logic [NUM_W-1:0]       sat_num_c;
	logic [VX_W-1:0]        vx_c;
	logic [VX_W-1:0]        vq_c;
	rth_dstage_t            data_c;

	// Advance a stage when it is empty or the next one takes its item
	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Pick the max channel (red over green over blue on ties) and the min
	always_comb begin
		if (red_in >= green_in && red_in >= blue_in) begin
			mx_c   = red_in;
			sext_c = SEXT_RED;
			diff_c = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
		end else if (green_in >= blue_in) begin
			mx_c   = green_in;
			sext_c = SEXT_GREEN;
			diff_c = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
		end else begin
			mx_c   = blue_in;
			sext_c = SEXT_BLUE;
			diff_c = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
		end
		mn_c = red_in;
		if (green_in < mn_c) mn_c = green_in;
		if (blue_in < mn_c) mn_c = blue_in;
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			mx_s1     <= mx_c;
			spread_s1 <= mx_c - mn_c;
			sext_s1   <= sext_c;
			diff_s1   <= diff_c;
		end
	end

	// Hue numerator: sextant base times spread plus 600 times the difference
	always_comb begin
		d600_c = (NUM_W+1)'(diff_s1) * (NUM_W+1)'(SEXTANT_TENTHS);
		case (sext_s1)
			SEXT_RED: begin
				base_c = (diff_s1 < 0) ? NUM_W'(spread_s1) * NUM_W'(FULL_TENTHS) : '0;
			end
			SEXT_GREEN: begin
				base_c = NUM_W'(spread_s1) * NUM_W'(2 * SEXTANT_TENTHS);
			end
			SEXT_BLUE: begin
				base_c = NUM_W'(spread_s1) * NUM_W'(4 * SEXTANT_TENTHS);
			end
			default: begin
				base_c = '0;
			end
		endcase
		total_c   = $signed({1'b0, base_c}) + d600_c;
		sat_num_c = NUM_W'(spread_s1) * NUM_W'(SAT_TENTHS);

		// floor(x / 255) as (x + 1 + (x >> 8)) >> 8, exact for x up to 255 * 100
		vx_c = VX_W'(mx_s1) * VX_W'(VALUE_SCALE);
		vq_c = vx_c + VX_W'(1) + (vx_c >> 8);

		// Seed both division lanes; the top bits start the partial remainder
		data_c.hue.pr  = total_c[NUM_W-1 -: CH_W];
		data_c.hue.low = total_c[QUOT_W-1:0];
		data_c.hue.q   = '0;
		data_c.hue.den = spread_s1;
		data_c.sat.pr  = sat_num_c[NUM_W-1 -: CH_W];
		data_c.sat.low = sat_num_c[QUOT_W-1:0];
		data_c.sat.q   = '0;
		data_c.sat.den = mx_s1;
		data_c.chroma  = (spread_s1 != '0);
		data_c.val     = VAL_W'(vq_c >> 8);
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			data_s2 <= data_c;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

// ----- sv/rth_div.sv -----
// Pipelined restoring divider: one quotient bit per stage on the hue and saturation lanes.
module rth_div import rth_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  rth_dstage_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rth_dstage_t out_data
);

	logic        v_s  [QUOT_W];
	rth_dstage_t st_s [QUOT_W];
	logic [QUOT_W-1:0] rdy;

	// One restoring step: shift in the next numerator bit, subtract if it fits
	function automatic rth_lane_t lane_step(rth_lane_t a);
		rth_lane_t     r;
		logic [CH_W:0] t;
		logic [CH_W:0] d;
		logic          ge;
		t      = {a.pr, a.low[QUOT_W-1]};
		d      = t - {1'b0, a.den};
		ge     = (t >= {1'b0, a.den});
		r.pr   = ge ? d[CH_W-1:0] : t[CH_W-1:0];
		r.low  = {a.low[QUOT_W-2:0], 1'b0};
		r.q    = {a.q[QUOT_W-2:0], ge};
		r.den  = a.den;
		return r;
	endfunction

	function automatic rth_dstage_t stage_step(rth_dstage_t a);
		rth_dstage_t r;
		r     = a;
		r.hue = lane_step(a.hue);
		r.sat = lane_step(a.sat);
		return r;
	endfunction

	// A stage may load when a bubble sits at or after it, or the output drains
	always_comb begin
		for (int k = 0; k < QUOT_W; k++) begin
			rdy[k] = out_ready;
			for (int j = k; j < QUOT_W; j++) begin
				rdy[k] = rdy[k] | !v_s[j];
			end
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUOT_W; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < QUOT_W; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	// Advance the payload one quotient bit per stage
	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) st_s[0] <= stage_step(in_data);
		for (int k = 1; k < QUOT_W; k++) begin
			if (rdy[k] && v_s[k-1]) st_s[k] <= stage_step(st_s[k-1]);
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[QUOT_W-1];
	assign out_data  = st_s[QUOT_W-1];

endmodule

// ----- sv/rth_back.sv -----
// Output stage: round the quotients, force zeros for gray pixels, hold the result item.
module rth_back import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rth_dstage_t      in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [HUE_W-1:0] hue,
	output logic [SAT_W-1:0] saturation,
	output logic [VAL_W-1:0] value_level
);

	logic             valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_W-1:0] sat_q;
	logic [VAL_W-1:0] val_q;

	logic             adv;
	logic             hue_up;
	logic             sat_up;
	logic [HUE_W-1:0] hue_c;
	logic [SAT_W-1:0] sat_c;

	assign adv      = !valid_q || !out_stall;
	assign in_ready = adv;

	// Round to nearest, ties up: bump when twice the remainder reaches the divisor
	always_comb begin
		hue_up = ({in_data.hue.pr, 1'b0} >= {1'b0, in_data.hue.den});
		sat_up = ({in_data.sat.pr, 1'b0} >= {1'b0, in_data.sat.den});
		hue_c  = HUE_W'(in_data.hue.q + QUOT_W'(hue_up));
		sat_c  = SAT_W'(in_data.sat.q + QUOT_W'(sat_up));
		if (!in_data.chroma) begin
			hue_c = '0;
			sat_c = '0;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	// Output payload, held while stalled
	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			hue_q <= hue_c;
			sat_q <= sat_c;
			val_q <= in_data.val;
		end
	end

	assign out_valid   = valid_q;
	assign hue         = hue_q;
	assign saturation  = sat_q;
	assign value_level = val_q;

endmodule

// ----- sv/rth_checker.sv -----
// Port-level checker for the RGB to HSV converter and its bind to the top level.
module rth_checker import rth_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             hsv_valid,
	input logic             hsv_stall,
	input logic [HUE_W-1:0] hue,
	input logic [SAT_W-1:0] saturation,
	input logic [VAL_W-1:0] value_level
);

	// Hold a stalled result item
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> hsv_valid)
		else $error("hsv_valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv_stall |=> $stable(hue) && $stable(saturation) && $stable(value_level))
		else $error("result item changed while stalled");

	// Keep every field of a result item in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue < HUE_W'(FULL_TENTHS) && saturation <= SAT_W'(SAT_TENTHS)
			&& value_level <= VAL_W'(VALUE_SCALE))
		else $error("result field out of range");

	// Zero saturation only for gray pixels, so a result with zero saturation must have zero hue
	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("nonzero hue with zero saturation");

endmodule

bind rgb_to_hsv_unit rth_checker u_rth_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.hsv_valid   (hsv_valid),
	.hsv_stall   (hsv_stall),
	.hue         (hue),
	.saturation  (saturation),
	.value_level (value_level)
);

// ----- tb/tb_rgb_to_hsv_unit.sv -----
// Self-checking testbench for the RGB to HSV converter: directed, random, back-pressure and full-rate items.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_unit;
	import rth_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int PIPE_LATENCY    = 15;
	localparam int DRAIN_CYCLES    = 4 * PIPE_LATENCY;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int CHANNEL_FULL    = (1 << CH_W) - 1;

	// One converted pixel as the block returns it
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [VAL_W-1:0] val;
	} hsv_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             pixel_valid = 1'b0;
	logic             pixel_stall;
	logic [CH_W-1:0]  red_in = '0;
	logic [CH_W-1:0]  green_in = '0;
	logic [CH_W-1:0]  blue_in = '0;
	logic             hsv_valid;
	logic             hsv_stall = 1'b0;
	logic [HUE_W-1:0] hue;
	logic [SAT_W-1:0] saturation;
	logic [VAL_W-1:0] value_level;

	hsv_t expected_hsv[$];
	int   error_count = 0;
	int   cycle_count = 0;
	bit   tx_gaps_on = 1'b0;
	bit   rx_stalls_on = 1'b0;
	int   hold_off_asked = 0;
	int   hold_off_seen = 0;
	int   hold_off_left = 0;
	int   rx_stall_left = 0;

	rgb_to_hsv_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hue         (hue),
		.saturation  (saturation),
		.value_level (value_level)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Gap length: mostly none, often short, now and then long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Compute hue, saturation and value of one pixel in fixed point
	function automatic hsv_t predict_hsv(input logic [CH_W-1:0] r8, g8, b8);
		int   r, g, b, mx, mn, spread, total;
		hsv_t res;
		r = r8;
		g = g8;
		b = b8;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		spread = mx - mn;
		res.hue = '0;
		res.sat = '0;
		if (spread > 0) begin
			// total is hue times spread, in tenths; red wins ties, then green
			if (mx == r) begin
				total = SEXTANT_TENTHS * (g - b);
				if (total < 0)
					total += FULL_TENTHS * spread;
			end else if (mx == g) begin
				total = 2 * SEXTANT_TENTHS * spread + SEXTANT_TENTHS * (b - r);
			end else begin
				total = 4 * SEXTANT_TENTHS * spread + SEXTANT_TENTHS * (r - g);
			end
			res.hue = HUE_W'((2 * total + spread) / (2 * spread));
			res.sat = SAT_W'((2 * SAT_TENTHS * spread + mx) / (2 * mx));
		end
		res.val = VAL_W'(mx * VALUE_SCALE / CHANNEL_FULL);
		return res;
	endfunction

	// Offer one pixel, hold it until accepted, then record its expected result
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		red_in      <= r;
		green_in    <= g;
		blue_in     <= b;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		expected_hsv.push_back(predict_hsv(r, g, b));
	endtask

	// Count cycles and give up at the limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Drive the output stall: long hold-offs on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_off_asked != hold_off_seen) begin
			hold_off_seen <= hold_off_asked;
			hold_off_left <= HOLD_OFF_CYCLES - 1;
			hsv_stall     <= 1'b1;
		end else if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			hsv_stall     <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			hsv_stall     <= 1'b1;
		end else begin
			hsv_stall <= 1'b0;
			if (rx_stalls_on && $urandom_range(0, 99) < 30)
				rx_stall_left <= pick_gap();
		end
	end

	// Compare each accepted result with the oldest expected one
	always @(posedge clk) begin
		hsv_t exp_item;
		if (arst_n && hsv_valid && !hsv_stall) begin
			if (expected_hsv.size() == 0) begin
				$display("%0t unexpected result: hue %0d sat %0d value %0d",
					$time, hue, saturation, value_level);
				error_count++;
			end else begin
				exp_item = expected_hsv.pop_front();
				if (hue !== exp_item.hue) begin
					$display("%0t hue mismatch: expected %0d, got %0d",
						$time, exp_item.hue, hue);
					error_count++;
				end
				if (saturation !== exp_item.sat) begin
					$display("%0t saturation mismatch: expected %0d, got %0d",
						$time, exp_item.sat, saturation);
					error_count++;
				end
				if (value_level !== exp_item.val) begin
					$display("%0t value_level mismatch: expected %0d, got %0d",
						$time, exp_item.val, value_level);
					error_count++;
				end
			end
		end
	end

	// Extremes, achromatic pixels, channel ties and wrapped red hues
	task automatic test_directed_pixels();
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd100);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd10,  8'd200);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd254);
		send_pixel(8'd12,  8'd200, 8'd99);
		send_pixel(8'd77,  8'd13,  8'd240);
		send_pixel(8'haa,  8'h55,  8'hff);
		send_pixel(8'h55,  8'haa,  8'h00);
	endtask

	// Random pixels, biased toward gray and tied channels, with idling on both sides
	task automatic test_random_pixels(input int count);
		logic [CH_W-1:0] r, g, b;
		int              kind;
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		for (int i = 0; i < count; i++) begin
			r    = CH_W'($urandom);
			g    = CH_W'($urandom);
			b    = CH_W'($urandom);
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					g = r;
					b = r;
				end
				1: g = r;
				2: b = g;
				3: b = r;
				4: begin
					g = r;
					b = (r == 8'd0) ? r : r - 8'd1;
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Hold the output off for a long stretch while pixels keep coming
	task automatic test_back_pressure(input int count);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		hold_off_asked++;
		for (int i = 0; i < count; i++)
			send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
	endtask

	// Stream pixels at full rate with no idling
	task automatic test_full_rate(input int count);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_pixels();
		test_random_pixels(1000);
		test_back_pressure(100);
		test_full_rate(150);

		// Drop valid and drain the pipeline
		pixel_valid  <= 1'b0;
		rx_stalls_on = 1'b1;
		while (expected_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_hsv.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
